// ----- hw/rtl/cbf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier flattener package
// Shared widths, payload structs, the Bernstein weight table and the
// reciprocal constant used for the rounding division.
// ----------------------------------------------------------------------------
package cbf_pkg;

    localparam int COORD_W   = 12;
    localparam int SEGMENTS  = 10;
    localparam int T_W       = $clog2(SEGMENTS + 1);
    localparam int CUBE      = SEGMENTS * SEGMENTS * SEGMENTS;
    localparam int HALF      = CUBE / 2;
    localparam int WEIGHT_W  = $clog2(CUBE + 1);
    localparam int PROD_W    = WEIGHT_W + COORD_W + 1;
    localparam int MAG_W     = $clog2(CUBE * (2 ** (COORD_W - 1)) + HALF + 1);
    localparam int SUM_W     = MAG_W + 1;
    localparam int CUBE_LOG  = $clog2(CUBE);
    localparam int DIV_SHIFT = MAG_W + CUBE_LOG;
    localparam longint unsigned RECIP = ((64'd1 << DIV_SHIFT) + CUBE - 1) / CUBE;
    localparam int RECIP_W   = $clog2(RECIP + 1);
    localparam int MUL_W     = MAG_W + RECIP_W;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [WEIGHT_W-1:0]       weight_t;
    typedef weight_t [3:0]             weight_set_t;
    typedef weight_set_t [SEGMENTS:0]  weight_tab_t;

    typedef struct packed {
        coord_t p0_x;
        coord_t p0_y;
        coord_t p1_x;
        coord_t p1_y;
        coord_t p2_x;
        coord_t p2_y;
        coord_t p3_x;
        coord_t p3_y;
    } cbf_in_t;

    typedef struct packed {
        coord_t seg_start_x;
        coord_t seg_start_y;
        coord_t seg_end_x;
        coord_t seg_end_y;
        logic   last_segment;
    } cbf_out_t;

    typedef struct packed {
        logic   first;
        logic   last;
        coord_t p0_x;
        coord_t p0_y;
    } cbf_tag_t;

    typedef struct packed {
        logic        valid;
        cbf_tag_t    tag;
        weight_set_t w;
        cbf_in_t     pts;
    } cbf_step_t;

    typedef struct packed {
        logic     valid;
        cbf_tag_t tag;
        coord_t   x;
        coord_t   y;
    } cbf_point_t;

    function automatic weight_tab_t build_weights();
        weight_tab_t tab;
        int          u;
        tab = '0;
        for (int t = 0; t <= SEGMENTS; t++)
        begin
            u = SEGMENTS - t;
            tab[t][0] = WEIGHT_W'(u * u * u);
            tab[t][1] = WEIGHT_W'(3 * u * u * t);
            tab[t][2] = WEIGHT_W'(3 * u * t * t);
            tab[t][3] = WEIGHT_W'(t * t * t);
        end
        return tab;
    endfunction

    localparam weight_tab_t WEIGHT_TAB = build_weights();

endpackage

// ----- hw/rtl/cubic_bezier_flattener.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier flattener
// Splits one cubic Bezier curve into a fixed number of line segments and
// emits one segment word per cycle while the output is not stalled.
//
//   Channel | Handshake            | Word
//   --------+----------------------+--------------------------------------
//   in      | in_valid / in_ready  | cbf_in_t: four control points
//   out     | out_valid / out_ready| cbf_out_t: segment start, end, last
//
// Each curve yields SEGMENTS (ten) segment words through the one-word-wide
// output: the sequencer issues one step per unstalled cycle into a five-stage
// evaluator. Each step passes the evaluator and output registers in turn.
// Reset clears the sequencer and all valid bits; no clearing pass is needed.
// A stall on the output freezes the whole pipeline; the next curve is
// accepted as soon as the last step of the current one is issued.
// ----------------------------------------------------------------------------
module cubic_bezier_flattener
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cbf_pkg::cbf_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output cbf_pkg::cbf_out_t out_data
);
    import cbf_pkg::*;

    logic       advance;
    cbf_step_t  step;
    cbf_point_t point;

    cbf_seq u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .advance  (advance),
        .step     (step)
    );

    cbf_eval u_eval
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .step    (step),
        .point   (point)
    );

    cbf_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .point     (point),
        .advance   (advance),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- hw/rtl/cbf_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier flattener step sequencer
// Holds the control points of one curve and issues one step per advancing
// cycle, with its Bernstein weights, until the last segment has been issued.
// ----------------------------------------------------------------------------
module cbf_seq
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  cbf_pkg::cbf_in_t in_data,
    input  logic             advance,
    output cbf_pkg::cbf_step_t step
);
    import cbf_pkg::*;

    logic           busy_reg;
    logic           busy_next;
    logic [T_W-1:0] t_reg;
    logic [T_W-1:0] t_next;
    cbf_in_t        pts_reg;
    cbf_in_t        pts_next;
    logic           issue;
    logic           at_last;
    logic           accept;

    always_comb
    begin
        at_last   = (t_reg == T_W'(SEGMENTS));
        issue     = busy_reg && advance;
        in_ready  = !busy_reg || (issue && at_last);
        accept    = in_valid && in_ready;
        busy_next = busy_reg;
        t_next    = t_reg;
        pts_next  = pts_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            t_next    = T_W'(1);
            pts_next  = in_data;
        end
        else if (issue)
        begin
            if (at_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                t_next = t_reg + T_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            t_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            t_reg    <= t_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pts_reg <= pts_next;
    end

    always_comb
    begin
        step.valid     = busy_reg;
        step.tag.first = (t_reg == T_W'(1));
        step.tag.last  = at_last;
        step.tag.p0_x  = pts_reg.p0_x;
        step.tag.p0_y  = pts_reg.p0_y;
        step.w         = WEIGHT_TAB[t_reg];
        step.pts       = pts_reg;
    end

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (t_reg != '0 && t_reg <= T_W'(SEGMENTS)))
        else $error("step index out of range while busy");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (busy_reg && t_reg == T_W'(1)))
        else $error("accepted curve did not start at the first step");

    a_step_incr: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && advance && !at_last) |=>
            (busy_reg && t_reg == T_W'($past(t_reg) + T_W'(1))))
        else $error("step index did not advance by one");

    a_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !advance) |=> (busy_reg && $stable(t_reg)))
        else $error("step index moved during a stall");

endmodule

// ----- hw/rtl/cbf_eval.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier flattener point evaluator
// Five-stage pipeline: weight products, weighted sum with rounding offset,
// magnitude, reciprocal multiply, then shift and sign restore.
// ----------------------------------------------------------------------------
module cbf_eval
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  cbf_pkg::cbf_step_t  step,
    output cbf_pkg::cbf_point_t point
);
    import cbf_pkg::*;

    localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);

    logic                     a_valid_reg;
    cbf_tag_t                 a_tag_reg;
    logic signed [PROD_W-1:0] a_prod_reg [2][4];
    logic signed [PROD_W-1:0] a_prod_next [2][4];

    logic                     b_valid_reg;
    cbf_tag_t                 b_tag_reg;
    logic signed [SUM_W-1:0]  b_sum_reg [2];
    logic signed [SUM_W-1:0]  b_sum_next [2];

    logic                     c_valid_reg;
    cbf_tag_t                 c_tag_reg;
    logic                     c_neg_reg [2];
    logic [MAG_W-1:0]         c_mag_reg [2];
    logic [MAG_W-1:0]         c_mag_next [2];

    logic                     d_valid_reg;
    cbf_tag_t                 d_tag_reg;
    logic                     d_neg_reg [2];
    logic [MUL_W-1:0]         d_mul_reg [2];
    logic [MUL_W-1:0]         d_mul_next [2];

    logic                     e_valid_reg;
    cbf_tag_t                 e_tag_reg;
    coord_t                   e_pt_reg [2];
    coord_t                   e_pt_next [2];

    coord_t                   coords [2][4];
    logic [COORD_W-1:0]       quot [2];

    always_comb
    begin
        coords[0][0] = step.pts.p0_x;
        coords[0][1] = step.pts.p1_x;
        coords[0][2] = step.pts.p2_x;
        coords[0][3] = step.pts.p3_x;
        coords[1][0] = step.pts.p0_y;
        coords[1][1] = step.pts.p1_y;
        coords[1][2] = step.pts.p2_y;
        coords[1][3] = step.pts.p3_y;
        for (int l = 0; l < 2; l++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                a_prod_next[l][k] = PROD_W'($signed({1'b0, step.w[k]}))
                                  * PROD_W'(coords[l][k]);
            end
            b_sum_next[l] = SUM_W'(a_prod_reg[l][0]) + SUM_W'(a_prod_reg[l][1])
                          + SUM_W'(a_prod_reg[l][2]) + SUM_W'(a_prod_reg[l][3])
                          + SUM_W'(HALF);
            c_mag_next[l] = b_sum_reg[l][SUM_W-1] ? MAG_W'(-b_sum_reg[l])
                                                  : MAG_W'(b_sum_reg[l]);
            d_mul_next[l] = MUL_W'(c_mag_reg[l]) * MUL_W'(RECIP_K);
            quot[l]       = COORD_W'(d_mul_reg[l] >> DIV_SHIFT);
            e_pt_next[l]  = d_neg_reg[l] ? -$signed(quot[l]) : $signed(quot[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= step.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_tag_reg <= step.tag;
            b_tag_reg <= a_tag_reg;
            c_tag_reg <= b_tag_reg;
            d_tag_reg <= c_tag_reg;
            e_tag_reg <= d_tag_reg;
            for (int l = 0; l < 2; l++)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    a_prod_reg[l][k] <= a_prod_next[l][k];
                end
                b_sum_reg[l] <= b_sum_next[l];
                c_neg_reg[l] <= b_sum_reg[l][SUM_W-1];
                c_mag_reg[l] <= c_mag_next[l];
                d_neg_reg[l] <= c_neg_reg[l];
                d_mul_reg[l] <= d_mul_next[l];
                e_pt_reg[l]  <= e_pt_next[l];
            end
        end
    end

    always_comb
    begin
        point.valid = e_valid_reg;
        point.tag   = e_tag_reg;
        point.x     = e_pt_reg[0];
        point.y     = e_pt_reg[1];
    end

endmodule

// ----- hw/rtl/cbf_out.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier flattener segment output stage
// Pairs each curve point with the previous one and holds the finished
// segment word until the consumer takes it; drives the pipeline advance.
// ----------------------------------------------------------------------------
module cbf_out
(
    input  logic                clk,
    input  logic                rst_n,
    input  cbf_pkg::cbf_point_t point,
    output logic                advance,
    output logic                out_valid,
    input  logic                out_ready,
    output cbf_pkg::cbf_out_t   out_data
);
    import cbf_pkg::*;

    logic     out_valid_reg;
    cbf_out_t out_data_reg;
    cbf_out_t out_data_next;
    coord_t   prev_x_reg;
    coord_t   prev_y_reg;

    always_comb
    begin
        advance = !out_valid_reg || out_ready;
        out_data_next.seg_start_x  = point.tag.first ? point.tag.p0_x : prev_x_reg;
        out_data_next.seg_start_y  = point.tag.first ? point.tag.p0_y : prev_y_reg;
        out_data_next.seg_end_x    = point.x;
        out_data_next.seg_end_y    = point.y;
        out_data_next.last_segment = point.tag.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= point.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && point.valid)
        begin
            out_data_reg <= out_data_next;
            prev_x_reg   <= point.x;
            prev_y_reg   <= point.y;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- bench/cbf_segment_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier flattener segment checker
// Watches both channels of the flattener. Every accepted curve is expanded
// into its line segments by a local fixed-step Bernstein evaluation, and every
// accepted segment word is compared field by field with the oldest segment
// still waiting. Failures and the number of waiting segments go to the top.
// ----------------------------------------------------------------------------
module cbf_segment_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  cbf_pkg::cbf_in_t  in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  cbf_pkg::cbf_out_t out_data,
    output int                fail_count,
    output int                pending
);

    import cbf_pkg::*;

    cbf_out_t segment_queue[$];
    coord_t   prev_x;
    coord_t   prev_y;

    initial
    begin
        fail_count = 0;
        pending    = 0;
        prev_x     = '0;
        prev_y     = '0;
    end

    function automatic coord_t bezier_coord(input coord_t a, input coord_t b,
                                            input coord_t c, input coord_t d,
                                            input int t);
        longint s;
        longint u;
        longint tt;
        longint cube;
        longint sum;
        s    = SEGMENTS;
        tt   = t;
        u    = s - tt;
        cube = s * s * s;
        sum  = u * u * u * longint'(a) + 3 * u * u * tt * longint'(b)
             + 3 * u * tt * tt * longint'(c) + tt * tt * tt * longint'(d);
        // Division truncates toward zero, so negative halves round up.
        return coord_t'((sum + cube / 2) / cube);
    endfunction

    task automatic flatten_curve(input cbf_in_t curve);
        cbf_out_t seg;
        coord_t   ex;
        coord_t   ey;
        prev_x = curve.p0_x;
        prev_y = curve.p0_y;
        for (int t = 1; t <= SEGMENTS; t++)
        begin
            ex = bezier_coord(curve.p0_x, curve.p1_x, curve.p2_x, curve.p3_x, t);
            ey = bezier_coord(curve.p0_y, curve.p1_y, curve.p2_y, curve.p3_y, t);
            seg.seg_start_x  = prev_x;
            seg.seg_start_y  = prev_y;
            seg.seg_end_x    = ex;
            seg.seg_end_y    = ey;
            seg.last_segment = (t == SEGMENTS);
            segment_queue.push_back(seg);
            prev_x = ex;
            prev_y = ey;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        cbf_out_t want;
        cbf_out_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                flatten_curve(in_data);
            if (out_valid && out_ready)
            begin
                got = out_data;
                if (segment_queue.size() == 0)
                begin
                    $error("segment word accepted with no segment pending");
                    fail_count++;
                end
                else
                begin
                    want = segment_queue.pop_front();
                    check_field("seg_start_x", want.seg_start_x, got.seg_start_x);
                    check_field("seg_start_y", want.seg_start_y, got.seg_start_y);
                    check_field("seg_end_x", want.seg_end_x, got.seg_end_x);
                    check_field("seg_end_y", want.seg_end_y, got.seg_end_y);
                    check_field("last_segment", int'(want.last_segment),
                                int'(got.last_segment));
                end
            end
        end
        pending = segment_queue.size();
    end

endmodule

// ----- bench/cubic_bezier_flattener_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cubic Bezier flattener testbench
// Feeds directed corner curves and then random curves to the flattener, with
// random gaps on both channels, a stretch without gaps and one long output
// stall that backs the block up. A separate checker predicts and compares
// every segment word; this top gives the verdict.
// ----------------------------------------------------------------------------
module cubic_bezier_flattener_tb;

    import cbf_pkg::*;

    localparam int IDLE_PCT       = 26;
    localparam int RANDOM_CURVES  = 455;
    localparam int STEADY_FIRST   = 250;
    localparam int STEADY_LAST    = 330;
    localparam int HOLD_AT        = 60;
    localparam int HOLD_CYCLES    = 150;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 1000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    cbf_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    cbf_out_t out_data;
    logic     in_fire;
    logic     steady;
    logic     hold_req;
    int       fail_count;
    int       pending;
    int       quiet_cycles;

    cubic_bezier_flattener uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    cbf_segment_checker checker_i
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_fire <= 1'b0;
        else
            in_fire <= in_valid && in_ready;
    end

    initial
    begin
        quiet_cycles = 0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("cubic_bezier_flattener_tb NOT OK");
            $finish;
        end
    end

    // The receiver drops ready at random, except during the steady stretch,
    // and holds it low for a long stretch once when asked.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            out_ready = steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic cbf_in_t make_curve(input int x0, input int y0,
                                           input int x1, input int y1,
                                           input int x2, input int y2,
                                           input int x3, input int y3);
        cbf_in_t c;
        c.p0_x = coord_t'(x0);
        c.p0_y = coord_t'(y0);
        c.p1_x = coord_t'(x1);
        c.p1_y = coord_t'(y1);
        c.p2_x = coord_t'(x2);
        c.p2_y = coord_t'(y2);
        c.p3_x = coord_t'(x3);
        c.p3_y = coord_t'(y3);
        return c;
    endfunction

    function automatic coord_t random_coord(input int kind);
        int pick;
        pick = $urandom_range(4);
        case (kind)
            0:
            begin
                case (pick)
                    0: return coord_t'(-2048);
                    1: return coord_t'(-1);
                    2: return coord_t'(0);
                    3: return coord_t'(1);
                    default: return coord_t'(2047);
                endcase
            end
            1: return coord_t'($urandom_range(16) - 8);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic cbf_in_t random_curve();
        cbf_in_t c;
        int      kind;
        kind   = ($urandom_range(9) < 6) ? 2 : $urandom_range(1);
        c.p0_x = random_coord(kind);
        c.p0_y = random_coord(kind);
        c.p1_x = random_coord(kind);
        c.p1_y = random_coord(kind);
        c.p2_x = random_coord(kind);
        c.p2_y = random_coord(kind);
        c.p3_x = random_coord(kind);
        c.p3_y = random_coord(kind);
        return c;
    endfunction

    // Called at a falling edge; returns at the falling edge after the word
    // was taken, leaving valid high so the next word can follow at once.
    task automatic send_curve(input cbf_in_t curve);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = curve;
        @(negedge clk);
        while (!in_fire)
            @(negedge clk);
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        steady   = 1'b0;
        hold_req = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_curve(make_curve(0, 0, 0, 0, 0, 0, 0, 0));
        send_curve(make_curve(2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047));
        send_curve(make_curve(-2048, -2048, -2048, -2048, -2048, -2048, -2048, -2048));
        send_curve(make_curve(-2048, -2048, 2047, 2047, -2048, -2048, 2047, 2047));
        send_curve(make_curve(2047, -2048, -2048, 2047, 2047, -2048, -2048, 2047));
        send_curve(make_curve(-2048, 2047, -683, 682, 682, -683, 2047, -2048));
        // A negative value exactly halfway between two integers rounds up.
        send_curve(make_curve(0, 0, 0, 0, 0, 0, -4, -4));
        send_curve(make_curve(0, 0, 0, 0, 0, 0, 4, 4));
        // A negative end point comes out one above itself.
        send_curve(make_curve(0, 0, 0, 0, 0, 0, -1, -1));
        send_curve(make_curve(5, -5, 5, -5, 5, -5, -2048, -2048));
        send_curve(make_curve(-1, -1, -1, -1, -1, -1, -1, -1));
        send_curve(make_curve(1365, -1366, 1365, -1366, 1365, -1366, 1365, -1366));
        send_curve(make_curve(-1366, 1365, -1366, 1365, -1366, 1365, -1366, 1365));
        send_curve(make_curve(100, -100, -300, 300, 500, -500, -700, 700));
        send_curve(make_curve(-7, 3, 11, -13, -2, 9, 6, -15));

        for (int i = 0; i < RANDOM_CURVES; i++)
        begin
            if (i == HOLD_AT)
                hold_req = 1'b1;
            steady = (i >= STEADY_FIRST) && (i < STEADY_LAST);
            send_curve(random_curve());
        end
        in_valid = 1'b0;
        steady   = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("cubic_bezier_flattener_tb OK");
        else
            $display("cubic_bezier_flattener_tb NOT OK");
        $finish;
    end

endmodule
